/* design/pida_pkg.sv */
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, beat payload types, register indexes, sequencer states and
// the divider status bundle for the anti-windup PID controller.
// ----------------------------------------------------------------------------
package pida_pkg;

    // Field widths
    localparam int MEAS_W      = 16;
    localparam int DT_W        = 16;
    localparam int GAIN_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int INTEG_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Internal arithmetic widths
    localparam int ERR_W       = MEAS_W + 1;          // setpoint - measured
    localparam int MUL_A_W     = GAIN_W + 1;          // shared multiplier, A side
    localparam int MUL_B_W     = ERR_W + 1;           // shared multiplier, B side
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;   // full product
    localparam int PROD_W      = GAIN_W + ERR_W;      // gain times error
    localparam int ACC_W       = 64;                  // gain_i * error * dt
    localparam int INC_W       = ACC_W - FRAC_W;      // integral increment
    localparam int INTEG_X_W   = INC_W + 2;           // unclamped integral
    localparam int DIV_NUM_W   = 64;
    localparam int DIV_DEN_W   = DT_W;
    localparam int DIV_STEPS   = DIV_NUM_W / 2;       // two quotient bits per cycle
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int D_SAT_SHIFT = 50;
    localparam int D_MAG_W     = D_SAT_SHIFT + 1;
    localparam int D_W         = D_MAG_W + 1;
    localparam int SUM_W       = D_W + 1;
    localparam int DRVQ_W      = SUM_W - FRAC_W;

    // Saturation bound of the derivative term
    localparam logic [DIV_NUM_W-1:0] D_SAT = DIV_NUM_W'(1) << D_SAT_SHIFT;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_LIMIT_LOW  = 3'd4,
        REG_LIMIT_HIGH = 3'd5
    } cfg_reg_t;

    // Input beat
    typedef struct packed {
        logic signed [MEAS_W-1:0] measured;
        logic        [DT_W-1:0]   step_time;
    } sample_t;

    // Output beat
    typedef struct packed {
        logic signed [MEAS_W-1:0] drive;
        logic                     held;
    } result_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_IH,
        ST_MUL_IL,
        ST_INT_ACC,
        ST_INT_DIV,
        ST_INT_SUM,
        ST_INT_CLAMP,
        ST_D_WAIT,
        ST_SUM_PD,
        ST_SUM_I,
        ST_TRUNC,
        ST_EMIT
    } state_t;

endpackage

/* design/pida_mul.sv */
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One 33 x 18 signed multiply with a registered product; the sequencer
// feeds it a new operand pair every cycle of its multiply states.
// ----------------------------------------------------------------------------
module pida_mul (
    input  logic                                  clk,
    input  logic signed [pida_pkg::MUL_A_W-1:0]   a,
    input  logic signed [pida_pkg::MUL_B_W-1:0]   b,
    output logic signed [pida_pkg::MUL_P_W-1:0]   product
);
    import pida_pkg::*;

    // Both operands are widened to the product width before the multiply.
    always_ff @(posedge clk)
    begin
        product <= MUL_P_W'(a) * MUL_P_W'(b);
    end

endmodule

/* design/pida_div.sv */
// ----------------------------------------------------------------------------
// Radix-4 restoring divider
// Unsigned 64-bit by 16-bit division, two quotient bits per cycle. The quotient
// builds up in the dividend shift register.
// ----------------------------------------------------------------------------
module pida_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pida_pkg::DIV_NUM_W-1:0]      dividend,
    input  logic [pida_pkg::DIV_DEN_W-1:0]      divisor,
    output logic [pida_pkg::DIV_NUM_W-1:0]      quotient,
    output pida_pkg::div_stat_t                 stat
);
    import pida_pkg::*;

    logic [DIV_NUM_W-1:0] shift_reg, shift_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   step_hi;
    logic [DIV_DEN_W:0]   step_lo;

    // One restoring step: returns the quotient bit over the new remainder.
    function automatic logic [DIV_DEN_W:0] div_step(
        input logic [DIV_DEN_W-1:0] rem,
        input logic                 bit_in,
        input logic [DIV_DEN_W-1:0] den
    );
        logic [DIV_DEN_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, den})
        begin
            div_step = {1'b1, DIV_DEN_W'(trial - {1'b0, den})};
        end
        else
        begin
            div_step = {1'b0, trial[DIV_DEN_W-1:0]};
        end
    endfunction

    // Two chained steps per cycle.
    assign step_hi = div_step(rem_reg, shift_reg[DIV_NUM_W-1], den_reg);
    assign step_lo = div_step(step_hi[DIV_DEN_W-1:0], shift_reg[DIV_NUM_W-2], den_reg);

    // Next-state logic for the iteration.
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            den_next   = divisor;
            cnt_next   = '0;
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[DIV_NUM_W-3:0], step_hi[DIV_DEN_W], step_lo[DIV_DEN_W]};
            rem_next   = step_lo[DIV_DEN_W-1:0];
            cnt_next   = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    assign quotient  = shift_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* design/pid_antiwindup_controller.sv */
// ----------------------------------------------------------------------------
// PID controller with conditional-integration anti-windup
// Fixed-point PID: the integral is frozen while the last drive sits at a
// limit and the error pushes further into it; derivative on measurement.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                               Direction   Beat
//   config    cfg_wr_en, cfg_index, cfg_data        in          register write
//   sample    sample_valid, sample_stall, sample    in          measured, step_time
//   result    result_valid, result_stall, result    out         drive, held
//
// A computed sample: ST_MUL_P to ST_MUL_IL issue the shared multiplies, ST_MUL_IL also
// starting the radix-4 divider for the derivative; the integral updates while it runs;
// ST_D_WAIT waits for it, then ST_SUM_PD to ST_EMIT sum, truncate and load the result.
// The first computed sample skips the divider; a zero step_time goes straight to ST_EMIT
// for the held drive. sample_stall is high from accept until the result is loaded; a
// stalled result holds the sequencer in its last state. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [pida_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pida_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  pida_pkg::sample_t                     sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output pida_pkg::result_t                     result
);
    import pida_pkg::*;

    // Configuration registers
    logic signed [MEAS_W-1:0]    setpoint_reg;
    logic signed [GAIN_W-1:0]    gain_p_reg;
    logic signed [GAIN_W-1:0]    gain_i_reg;
    logic signed [GAIN_W-1:0]    gain_d_reg;
    logic signed [MEAS_W-1:0]    limit_low_reg;
    logic signed [MEAS_W-1:0]    limit_high_reg;

    // Controller state
    state_t                      state_reg, state_next;
    logic signed [INTEG_W-1:0]   integral_reg, integral_next;
    logic signed [MEAS_W-1:0]    last_meas_reg, last_meas_next;
    logic signed [MEAS_W-1:0]    last_drive_reg, last_drive_next;
    logic                        first_step_reg, first_step_next;
    logic                        result_valid_reg, result_valid_next;

    // Per-sample working registers
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic signed [ERR_W-1:0]     dm_reg, dm_next;
    logic        [DT_W-1:0]      dt_reg, dt_next;
    logic                        held_reg, held_next;
    logic                        first_item_reg, first_item_next;
    logic signed [PROD_W-1:0]    p_reg, p_next;
    logic signed [PROD_W-1:0]    t_reg, t_next;
    logic signed [PROD_W-1:0]    nd_reg, nd_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [INC_W-1:0]     inc_reg, inc_next;
    logic signed [INTEG_X_W-1:0] integ_reg, integ_next;
    logic signed [D_W-1:0]       d_reg, d_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic signed [DRVQ_W-1:0]    drvq_reg, drvq_next;
    result_t                     result_reg, result_next;

    // Shared units
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_prod;
    logic                        div_start;
    logic [DIV_NUM_W-1:0]        div_dividend;
    logic [DIV_NUM_W-1:0]        div_quot;
    div_stat_t                   div_stat;

    // Helper values
    logic signed [ERR_W-1:0]     sp_x;
    logic signed [ERR_W-1:0]     meas_x;
    logic signed [ERR_W-1:0]     last_meas_x;
    logic signed [ACC_W-1:0]     acc_bias;
    logic signed [SUM_W-1:0]     sum_bias;
    logic signed [INTEG_W-1:0]   hi_q;
    logic signed [INTEG_W-1:0]   lo_q;
    logic signed [PROD_W-1:0]    nd_abs;
    logic [D_MAG_W-1:0]          d_mag;
    logic                        worsen;
    logic signed [MEAS_W-1:0]    drive_clamp;

    pida_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_prod)
    );

    pida_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Error and measurement delta operands, sign extended.
    assign sp_x        = ERR_W'(setpoint_reg);
    assign meas_x      = ERR_W'(sample.measured);
    assign last_meas_x = ERR_W'(last_meas_reg);

    // Truncation toward zero: negative values get 2^16 - 1 added before the shift.
    assign acc_bias = acc_reg + $signed({{(ACC_W - FRAC_W){1'b0}}, {FRAC_W{acc_reg[ACC_W-1]}}});
    assign sum_bias = sum_reg + $signed({{(SUM_W - FRAC_W){1'b0}}, {FRAC_W{sum_reg[SUM_W-1]}}});

    // Integral limits in Q16.16.
    assign hi_q = $signed({limit_high_reg, {FRAC_W{1'b0}}});
    assign lo_q = $signed({limit_low_reg, {FRAC_W{1'b0}}});

    // Derivative numerator magnitude, scaled by 2^16 for the divider.
    assign nd_abs       = nd_reg[PROD_W-1] ? -nd_reg : nd_reg;
    assign div_dividend = {nd_abs[DIV_NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

    // Saturated derivative magnitude.
    assign d_mag = (div_quot > D_SAT) ? D_MAG_W'(D_SAT) : div_quot[D_MAG_W-1:0];

    // The integral freezes while the error drives further into a saturated output.
    assign worsen = ((err_reg > 0) && (last_drive_reg >= limit_high_reg)) ||
                    ((err_reg < 0) && (last_drive_reg <= limit_low_reg));

    // Output clamp: upper limit first, so the upper one wins when limits cross.
    always_comb
    begin
        if (drvq_reg > DRVQ_W'(limit_high_reg))
        begin
            drive_clamp = limit_high_reg;
        end
        else if (drvq_reg < DRVQ_W'(limit_low_reg))
        begin
            drive_clamp = limit_low_reg;
        end
        else
        begin
            drive_clamp = drvq_reg[MEAS_W-1:0];
        end
    end

    // Sequencer: next state, shared unit operands and datapath updates.
    always_comb
    begin
        state_next        = state_reg;
        integral_next     = integral_reg;
        last_meas_next    = last_meas_reg;
        last_drive_next   = last_drive_reg;
        first_step_next   = first_step_reg;
        result_valid_next = result_valid_reg;
        err_next          = err_reg;
        dm_next           = dm_reg;
        dt_next           = dt_reg;
        held_next         = held_reg;
        first_item_next   = first_item_reg;
        p_next            = p_reg;
        t_next            = t_reg;
        nd_next           = nd_reg;
        acc_next          = acc_reg;
        inc_next          = inc_reg;
        integ_next        = integ_reg;
        d_next            = d_reg;
        sum_next          = sum_reg;
        drvq_next         = drvq_reg;
        result_next       = result_reg;
        mul_a             = '0;
        mul_b             = '0;
        div_start         = 1'b0;

        // A taken result frees the output register.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    if (sample.step_time == '0)
                    begin
                        held_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        held_next       = 1'b0;
                        err_next        = sp_x - meas_x;
                        dm_next         = meas_x - last_meas_x;
                        dt_next         = sample.step_time;
                        first_item_next = first_step_reg;
                        first_step_next = 1'b0;
                        last_meas_next  = sample.measured;
                        state_next      = ST_MUL_P;
                    end
                end
            end
            ST_MUL_P:
            begin
                mul_a      = MUL_A_W'(gain_p_reg);
                mul_b      = MUL_B_W'(err_reg);
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                p_next     = PROD_W'(mul_prod);
                mul_a      = MUL_A_W'(gain_i_reg);
                mul_b      = MUL_B_W'(err_reg);
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                t_next     = PROD_W'(mul_prod);
                mul_a      = MUL_A_W'(gain_d_reg);
                mul_b      = MUL_B_W'(dm_reg);
                state_next = ST_MUL_IH;
            end
            ST_MUL_IH:
            begin
                // Upper part of gain_i * error times dt.
                nd_next    = PROD_W'(mul_prod);
                mul_a      = MUL_A_W'($signed(t_reg[PROD_W-1:32]));
                mul_b      = $signed({{(MUL_B_W - DT_W){1'b0}}, dt_reg});
                state_next = ST_MUL_IL;
            end
            ST_MUL_IL:
            begin
                // Lower part; the derivative division starts alongside, except for the first sample.
                acc_next   = $signed({mul_prod[31:0], 32'b0});
                mul_a      = $signed({1'b0, t_reg[31:0]});
                mul_b      = $signed({{(MUL_B_W - DT_W){1'b0}}, dt_reg});
                div_start  = !first_item_reg;
                state_next = ST_INT_ACC;
            end
            ST_INT_ACC:
            begin
                acc_next   = acc_reg + $signed({{(ACC_W - 48){1'b0}}, mul_prod[47:0]});
                state_next = ST_INT_DIV;
            end
            ST_INT_DIV:
            begin
                inc_next   = INC_W'(acc_bias >>> FRAC_W);
                state_next = ST_INT_SUM;
            end
            ST_INT_SUM:
            begin
                integ_next = INTEG_X_W'(integral_reg) + INTEG_X_W'(inc_reg);
                state_next = ST_INT_CLAMP;
            end
            ST_INT_CLAMP:
            begin
                if (!worsen)
                begin
                    if (integ_reg > INTEG_X_W'(hi_q))
                    begin
                        integral_next = hi_q;
                    end
                    else if (integ_reg < INTEG_X_W'(lo_q))
                    begin
                        integral_next = lo_q;
                    end
                    else
                    begin
                        integral_next = INTEG_W'(integ_reg);
                    end
                end
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT:
            begin
                // The derivative opposes the measurement change.
                if (first_item_reg)
                begin
                    d_next     = '0;
                    state_next = ST_SUM_PD;
                end
                else if (!div_stat.busy && div_stat.done)
                begin
                    d_next     = nd_reg[PROD_W-1] ? $signed(D_W'(d_mag)) : -$signed(D_W'(d_mag));
                    state_next = ST_SUM_PD;
                end
            end
            ST_SUM_PD:
            begin
                sum_next   = SUM_W'(p_reg) + SUM_W'(d_reg);
                state_next = ST_SUM_I;
            end
            ST_SUM_I:
            begin
                sum_next   = sum_reg + SUM_W'(integral_reg);
                state_next = ST_TRUNC;
            end
            ST_TRUNC:
            begin
                drvq_next  = DRVQ_W'(sum_bias >>> FRAC_W);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait here while the previous result is still stalled.
                if (!(result_valid_reg && result_stall))
                begin
                    result_valid_next = 1'b1;
                    result_next.held  = held_reg;
                    if (held_reg)
                    begin
                        result_next.drive = last_drive_reg;
                    end
                    else
                    begin
                        result_next.drive = drive_clamp;
                        last_drive_next   = drive_clamp;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= 16'sh8000;
            limit_high_reg <= 16'sh7FFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SETPOINT:   setpoint_reg   <= cfg_data[MEAS_W-1:0];
                REG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                REG_LIMIT_LOW:  limit_low_reg  <= cfg_data[MEAS_W-1:0];
                REG_LIMIT_HIGH: limit_high_reg <= cfg_data[MEAS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control and controller state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            integral_reg     <= '0;
            last_meas_reg    <= '0;
            last_drive_reg   <= '0;
            first_step_reg   <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            integral_reg     <= integral_next;
            last_meas_reg    <= last_meas_next;
            last_drive_reg   <= last_drive_next;
            first_step_reg   <= first_step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        err_reg        <= err_next;
        dm_reg         <= dm_next;
        dt_reg         <= dt_next;
        held_reg       <= held_next;
        first_item_reg <= first_item_next;
        p_reg          <= p_next;
        t_reg          <= t_next;
        nd_reg         <= nd_next;
        acc_reg        <= acc_next;
        inc_reg        <= inc_next;
        integ_reg      <= integ_next;
        d_reg          <= d_next;
        sum_reg        <= sum_next;
        drvq_reg       <= drvq_next;
        result_reg     <= result_next;
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
